// ===== hw/rtl/egcd_pkg.sv =====
// egcd_pkg: shared constants and types for the extended gcd block
// used by egcd_ctrl, egcd_dp and extended_gcd; no dependencies
package egcd_pkg;

  localparam int unsigned EGCD_DATA_WIDTH = 32;

  // commands from the sequencer to the shift/subtract unit
  typedef struct packed {
    logic load;   // take a new operand pair
    logic init;   // start a quotient step
    logic shift;  // align divisor one bit up
    logic sub;    // one restoring subtract bit
    logic emit;   // copy finished result to the output register
  } egcd_cmd_t;

  // status from the unit back to the sequencer
  typedef struct packed {
    logic rc_zero;  // current remainder is zero, recurrence done
    logic fits;     // divisor may move up one more bit
    logic k_zero;   // lowest quotient bit reached
  } egcd_sts_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_ALIGN = 4'b0100,
    S_SUB   = 4'b1000
  } egcd_state_e;

endpackage

// ===== hw/rtl/extended_gcd.sv =====
// extended_gcd: gcd and Bezout coefficients by the quotient-based Euclidean recurrence
// each quotient step first aligns the divisor upwards and then runs a restoring subtract
// for each quotient bit in the shared shift/subtract unit; when operand b is zero, no
// quotient step runs and the result goes straight to the output register
// throughput: one transaction at a time; the next is taken the cycle after the result enters
// the output register, and a finished result waits while that register is still full
// reset: asynchronous, active low; clears the sequencer and the output valid only
module extended_gcd import egcd_pkg::*; #(
  parameter int unsigned DATA_WIDTH = EGCD_DATA_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DATA_WIDTH-2:0] operand_a_i,
  input  logic [DATA_WIDTH-2:0] operand_b_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-2:0] divisor_o,
  output logic [DATA_WIDTH-1:0] coef_a_o,
  output logic [DATA_WIDTH-1:0] coef_b_o
);

  egcd_cmd_t cmd;
  egcd_sts_t sts;

  egcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  egcd_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .divisor_o   (divisor_o),
    .coef_a_o    (coef_a_o),
    .coef_b_o    (coef_b_o)
  );

endmodule

// ===== hw/rtl/egcd_dp.sv =====
// egcd_dp: remainder and coefficient registers with the shared shift/subtract unit
// depends on egcd_pkg
module egcd_dp import egcd_pkg::*; #(
  parameter int unsigned DATA_WIDTH = EGCD_DATA_WIDTH
) (
  input  logic                  clk_i,
  input  logic [DATA_WIDTH-2:0] operand_a_i,
  input  logic [DATA_WIDTH-2:0] operand_b_i,
  input  egcd_cmd_t             cmd_i,
  output egcd_sts_t             sts_o,
  output logic [DATA_WIDTH-2:0] divisor_o,
  output logic [DATA_WIDTH-1:0] coef_a_o,
  output logic [DATA_WIDTH-1:0] coef_b_o
);

  localparam int unsigned OpW = DATA_WIDTH - 1;
  localparam int unsigned KW  = (OpW > 1) ? $clog2(OpW) : 1;

  logic [OpW-1:0]        rp_q, rc_q, d_q;
  logic [DATA_WIDTH-1:0] xp_q, xc_q, yp_q, yc_q, xs_q, ys_q;
  logic [KW-1:0]         k_q;
  logic [OpW-1:0]        div_q;
  logic [DATA_WIDTH-1:0] ca_q, cb_q;

  logic                  ge;
  logic [OpW-1:0]        rp_sub;
  logic [DATA_WIDTH-1:0] xp_sub, yp_sub;

  // one restoring bit: subtract shifted divisor and shifted coefficients
  assign ge     = (d_q <= rp_q);
  assign rp_sub = ge ? (rp_q - d_q) : rp_q;
  assign xp_sub = ge ? (xp_q - xs_q) : xp_q;
  assign yp_sub = ge ? (yp_q - ys_q) : yp_q;

  assign sts_o.rc_zero = (rc_q == '0);
  assign sts_o.fits    = ({d_q, 1'b0} <= {1'b0, rp_q});
  assign sts_o.k_zero  = (k_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rp_q <= operand_a_i;
      rc_q <= operand_b_i;
      xp_q <= DATA_WIDTH'(1);
      xc_q <= '0;
      yp_q <= '0;
      yc_q <= DATA_WIDTH'(1);
    end else if (cmd_i.init) begin
      d_q  <= rc_q;
      xs_q <= xc_q;
      ys_q <= yc_q;
      k_q  <= '0;
    end else if (cmd_i.shift) begin
      d_q  <= {d_q[OpW-2:0], 1'b0};
      xs_q <= {xs_q[DATA_WIDTH-2:0], 1'b0};
      ys_q <= {ys_q[DATA_WIDTH-2:0], 1'b0};
      k_q  <= k_q + KW'(1);
    end else if (cmd_i.sub) begin
      if (k_q == '0) begin
        // quotient complete: rotate the recurrence
        rp_q <= rc_q;
        rc_q <= rp_sub;
        xp_q <= xc_q;
        xc_q <= xp_sub;
        yp_q <= yc_q;
        yc_q <= yp_sub;
      end else begin
        rp_q <= rp_sub;
        xp_q <= xp_sub;
        yp_q <= yp_sub;
        d_q  <= {1'b0, d_q[OpW-1:1]};
        xs_q <= {xs_q[DATA_WIDTH-1], xs_q[DATA_WIDTH-1:1]};
        ys_q <= {ys_q[DATA_WIDTH-1], ys_q[DATA_WIDTH-1:1]};
        k_q  <= k_q - KW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      div_q <= rp_q;
      ca_q  <= xp_q;
      cb_q  <= yp_q;
    end
  end

  assign divisor_o = div_q;
  assign coef_a_o  = ca_q;
  assign coef_b_o  = cb_q;

endmodule

// ===== hw/rtl/egcd_ctrl.sv =====
// egcd_ctrl: sequencer for the extended gcd iteration and the handshakes
// depends on egcd_pkg
module egcd_ctrl import egcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  egcd_sts_t sts_i,
  output egcd_cmd_t cmd_o
);

  egcd_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.rc_zero) begin
          // result waits here until the output register is free
          if (!out_valid_q || out_ready_i) begin
            cmd_o.emit  = 1'b1;
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
        end else begin
          cmd_o.init = 1'b1;
          state_d    = S_ALIGN;
        end
      end
      S_ALIGN: begin
        if (sts_i.fits) begin
          cmd_o.shift = 1'b1;
        end else begin
          state_d = S_SUB;
        end
      end
      S_SUB: begin
        cmd_o.sub = 1'b1;
        if (sts_i.k_zero) begin
          state_d = S_CHECK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== test/extended_gcd_tb.sv =====
// extended_gcd_tb: self-checking testbench for extended_gcd, gcd and Bezout coefficients
// predicts each result with its own Euclidean recurrence and checks it in order
// depends on egcd_pkg and extended_gcd only
module extended_gcd_tb;
  import egcd_pkg::*;

  localparam int unsigned W = EGCD_DATA_WIDTH;
  localparam int unsigned RANDOM_PER_PHASE = 138;
  localparam int unsigned SETTLE_CYCLES = 300;

  typedef struct packed {
    logic [W-2:0] a;
    logic [W-2:0] b;
  } operand_pair_t;

  typedef struct packed {
    logic [W-2:0] divisor;
    logic [W-1:0] coef_a;
    logic [W-1:0] coef_b;
  } bezout_t;

  typedef struct packed {
    operand_pair_t pair;
    bezout_t       res;
  } bezout_expect_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         in_valid_i = 1'b0;
  logic         in_ready_o;
  logic [W-2:0] operand_a_i = '0;
  logic [W-2:0] operand_b_i = '0;
  logic         out_valid_o;
  logic         out_ready_i = 1'b0;
  logic [W-2:0] divisor_o;
  logic [W-1:0] coef_a_o;
  logic [W-1:0] coef_b_o;

  operand_pair_t  operand_pairs_q[$];
  bezout_expect_t bezout_expect_q[$];
  operand_pair_t  next_pair;
  bezout_expect_t want;
  idle_mode_e     idle_mode;
  int unsigned    sent_cnt = 0;
  int unsigned    taken_cnt = 0;
  int unsigned    mismatches = 0;

  extended_gcd #(
    .DATA_WIDTH(W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .divisor_o  (divisor_o),
    .coef_a_o   (coef_a_o),
    .coef_b_o   (coef_b_o)
  );

  always #5 clk_i = ~clk_i;

  // quotient-based recurrence, coefficients kept modulo 2^64
  function automatic bezout_t solve_bezout(logic [W-2:0] a, logic [W-2:0] b);
    logic [63:0] r_prev, r_cur, quo, t;
    logic [63:0] x_prev, x_cur, y_prev, y_cur;
    bezout_t res;
    r_prev = 64'(a);
    r_cur  = 64'(b);
    x_prev = 64'd1;
    x_cur  = 64'd0;
    y_prev = 64'd0;
    y_cur  = 64'd1;
    while (r_cur != 64'd0) begin
      quo    = r_prev / r_cur;
      t      = r_prev - quo * r_cur;
      r_prev = r_cur;
      r_cur  = t;
      t      = x_prev - quo * x_cur;
      x_prev = x_cur;
      x_cur  = t;
      t      = y_prev - quo * y_cur;
      y_prev = y_cur;
      y_cur  = t;
    end
    res.divisor = r_prev[W-2:0];
    res.coef_a  = x_prev[W-1:0];
    res.coef_b  = y_prev[W-1:0];
    return res;
  endfunction

  function automatic logic [63:0] fibonacci(int unsigned k);
    logic [63:0] f0, f1, t;
    f0 = 64'd0;
    f1 = 64'd1;
    for (int unsigned i = 0; i < k; i++) begin
      t  = f0 + f1;
      f0 = f1;
      f1 = t;
    end
    return f0;
  endfunction

  function automatic operand_pair_t random_pair();
    operand_pair_t p;
    logic [63:0]   g, m, n;
    int unsigned   k;
    case ($urandom_range(9))
      0, 1, 2: begin
        m = 64'($urandom);
        n = 64'($urandom);
      end
      3, 4: begin
        g = 64'($urandom_range(1, 1000));
        m = g * 64'($urandom_range(1, 2000000));
        n = g * 64'($urandom_range(1, 2000000));
      end
      5: begin
        m = 64'($urandom_range(0, 64));
        n = 64'($urandom_range(0, 64));
      end
      6: begin
        // consecutive fibonacci numbers give the longest recurrence
        k = $urandom_range(2, 46);
        m = fibonacci(k);
        n = fibonacci(k - 1);
        if ($urandom_range(1)) begin
          g = m;
          m = n;
          n = g;
        end
      end
      7: begin
        m = 64'($urandom) >> $urandom_range(31);
        n = 64'd0;
        if ($urandom_range(1)) begin
          n = m;
          m = 64'd0;
        end
      end
      8: begin
        n = 64'($urandom_range(1, 100000));
        m = n * 64'($urandom_range(1, 20000));
      end
      default: begin
        m = 64'($urandom) >> $urandom_range(31);
        n = 64'($urandom) >> $urandom_range(31);
      end
    endcase
    p.a = m[W-2:0];
    p.b = n[W-2:0];
    return p;
  endfunction

  function automatic int unsigned idle_pct(logic receiver);
    case (idle_mode)
      IDLE_SEND: return receiver ? 0 : 56;
      IDLE_RECV: return receiver ? 56 : 0;
      IDLE_BOTH: return 36;
      default:   return 0;
    endcase
  endfunction

  task automatic push_pair(logic [63:0] a, logic [63:0] b);
    operand_pair_t p;
    p.a = a[W-2:0];
    p.b = b[W-2:0];
    operand_pairs_q = {operand_pairs_q, p};
  endtask

  task automatic flag_mismatch(string what, operand_pair_t pair, logic [63:0] got,
                               logic [63:0] exp_val);
    $display("[%0t] mismatch %s: a=%0d b=%0d got %0h want %0h", $realtime, what,
             pair.a, pair.b, got, exp_val);
    mismatches++;
  endtask

  task automatic wait_drained();
    while (operand_pairs_q.size() != 0 || in_valid_i || bezout_expect_q.size() != 0)
      @(negedge clk_i);
  endtask

  // result check first, then record the accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (bezout_expect_q.size() == 0) begin
          flag_mismatch("unexpected result", '0, 64'(divisor_o), 64'd0);
        end else begin
          want = bezout_expect_q.pop_front();
          if (divisor_o !== want.res.divisor)
            flag_mismatch("divisor", want.pair, 64'(divisor_o), 64'(want.res.divisor));
          if (coef_a_o !== want.res.coef_a)
            flag_mismatch("coef_a", want.pair, 64'(coef_a_o), 64'(want.res.coef_a));
          if (coef_b_o !== want.res.coef_b)
            flag_mismatch("coef_b", want.pair, 64'(coef_b_o), 64'(want.res.coef_b));
        end
      end
      if (in_valid_i && in_ready_o) begin
        want.pair.a = operand_a_i;
        want.pair.b = operand_b_i;
        want.res    = solve_bezout(operand_a_i, operand_b_i);
        bezout_expect_q = {bezout_expect_q, want};
        taken_cnt++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || taken_cnt == sent_cnt)) begin
      if (operand_pairs_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
        next_pair = operand_pairs_q.pop_front();
        operand_a_i <= next_pair.a;
        operand_b_i <= next_pair.b;
        in_valid_i  <= 1'b1;
        sent_cnt++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  initial begin
    #8000000;
    $display("extended_gcd verification failed");
    $finish;
  end

  initial begin
    rst_ni    = 1'b0;
    idle_mode = IDLE_NONE;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // both zero, one operand zero, extremes, longest recurrence, equal and ordered pairs
    push_pair(64'd0, 64'd0);
    push_pair(64'd5, 64'd0);
    push_pair(64'd0, 64'd7);
    push_pair(64'h7fff_ffff, 64'd0);
    push_pair(64'd0, 64'h7fff_ffff);
    push_pair(64'h7fff_ffff, 64'h7fff_ffff);
    push_pair(64'h7fff_ffff, 64'd1);
    push_pair(64'd1, 64'h7fff_ffff);
    push_pair(64'h7fff_ffff, 64'h7fff_fffe);
    push_pair(64'd1, 64'd1);
    push_pair(64'd1, 64'd0);
    push_pair(64'd1836311903, 64'd1134903170);
    push_pair(64'd1134903170, 64'd1836311903);
    push_pair(64'h4000_0000, 64'h2000_0000);
    push_pair(64'h5555_5555, 64'h2aaa_aaaa);
    push_pair(64'd12, 64'd18);
    push_pair(64'd18, 64'd12);
    push_pair(64'd240, 64'd46);
    push_pair(64'd1000000007, 64'd998244353);
    push_pair(64'd3, 64'd3);

    for (int m = 0; m < 4; m++) begin
      idle_mode = idle_mode_e'(m);
      repeat (RANDOM_PER_PHASE) operand_pairs_q = {operand_pairs_q, random_pair()};
      wait_drained();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && bezout_expect_q.size() == 0) begin
      $display("extended_gcd verification clean");
    end else begin
      $display("extended_gcd verification failed");
    end
    $finish;
  end

endmodule

// ===== extended_gcd.f =====
hw/rtl/egcd_pkg.sv
hw/rtl/egcd_dp.sv
hw/rtl/egcd_ctrl.sv
hw/rtl/extended_gcd.sv
test/extended_gcd_tb.sv
